### sv/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared constants and types for the barycentric point-in-triangle core.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int CoordWidthDef = 16;
    localparam int FracBitsDef   = 14;
    localparam int TOL_W         = 14;
    localparam logic [TOL_W-1:0] TOL_RESET = 14'd16;

    // Control bits that travel alongside each item through the pipeline.
    typedef struct packed {
        logic valid;
        logic degen;
        logic in_tri;
    } t_ctl;

endpackage

### sv/ptb_geom.sv
// ----------------------------------------------------------------------------
// ptb_geom
// Edge vectors, the six cross-product terms, and the signed determinant and
// numerators normalised to a non-negative determinant. Three register stages.
// ----------------------------------------------------------------------------
module ptb_geom #(
    parameter int CW = ptb_pkg::CoordWidthDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [31:0]              i_a_pos,
    input  logic [31:0]              i_b_pos,
    input  logic [31:0]              i_c_pos,
    input  logic [31:0]              i_a_tex,
    input  logic [31:0]              i_b_tex,
    input  logic [31:0]              i_c_tex,
    input  logic [31:0]              i_pt,
    output ptb_pkg::t_ctl            o_ctl,
    output logic signed [2*CW+2:0]   o_den,
    output logic signed [2*CW+2:0]   o_nu,
    output logic signed [2*CW+2:0]   o_nv,
    output logic signed [CW:0]       o_dcx,
    output logic signed [CW:0]       o_dcy,
    output logic signed [CW:0]       o_dbx,
    output logic signed [CW:0]       o_dby,
    output logic signed [CW-1:0]     o_tax,
    output logic signed [CW-1:0]     o_tay
);
    import ptb_pkg::*;

    localparam int DIFW = CW + 1;
    localparam int PW   = 2 * DIFW;
    localparam int XW   = PW + 1;
    localparam int EXW  = 32 + 2 * CW;

    function automatic logic signed [CW-1:0] f_hi(input logic [31:0] w);
        logic [EXW-1:0] e;
        e = {(2*CW)'(0), w};
        return $signed(e[CW +: CW]);
    endfunction

    function automatic logic signed [CW-1:0] f_lo(input logic [31:0] w);
        return $signed(w[0 +: CW]);
    endfunction

    logic signed [CW-1:0] ax, ay, bx, by, cx, cy, px, py;
    logic signed [CW-1:0] tax, tay, tbx, tby, tcx, tcy;

    assign ax  = f_hi(i_a_pos);
    assign ay  = f_lo(i_a_pos);
    assign bx  = f_hi(i_b_pos);
    assign by  = f_lo(i_b_pos);
    assign cx  = f_hi(i_c_pos);
    assign cy  = f_lo(i_c_pos);
    assign px  = f_hi(i_pt);
    assign py  = f_lo(i_pt);
    assign tax = f_hi(i_a_tex);
    assign tay = f_lo(i_a_tex);
    assign tbx = f_hi(i_b_tex);
    assign tby = f_lo(i_b_tex);
    assign tcx = f_hi(i_c_tex);
    assign tcy = f_lo(i_c_tex);

    // Stage 1: differences.
    logic                   r1_vld;
    logic signed [DIFW-1:0] r1_v0x, r1_v0y, r1_v1x, r1_v1y, r1_v2x, r1_v2y;
    logic signed [DIFW-1:0] r1_dcx, r1_dcy, r1_dbx, r1_dby;
    logic signed [CW-1:0]   r1_tax, r1_tay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v0x <= DIFW'(cx) - DIFW'(ax);
            r1_v0y <= DIFW'(cy) - DIFW'(ay);
            r1_v1x <= DIFW'(bx) - DIFW'(ax);
            r1_v1y <= DIFW'(by) - DIFW'(ay);
            r1_v2x <= DIFW'(px) - DIFW'(ax);
            r1_v2y <= DIFW'(py) - DIFW'(ay);
            r1_dcx <= DIFW'(tcx) - DIFW'(tax);
            r1_dcy <= DIFW'(tcy) - DIFW'(tay);
            r1_dbx <= DIFW'(tbx) - DIFW'(tax);
            r1_dby <= DIFW'(tby) - DIFW'(tay);
            r1_tax <= tax;
            r1_tay <= tay;
        end
    end

    // Stage 2: the six cross-product terms.
    logic                   r2_vld;
    logic signed [PW-1:0]   r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    logic signed [DIFW-1:0] r2_dcx, r2_dcy, r2_dbx, r2_dby;
    logic signed [CW-1:0]   r2_tax, r2_tay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p0  <= PW'(r1_v0x) * PW'(r1_v1y);
            r2_p1  <= PW'(r1_v0y) * PW'(r1_v1x);
            r2_p2  <= PW'(r1_v2x) * PW'(r1_v1y);
            r2_p3  <= PW'(r1_v2y) * PW'(r1_v1x);
            r2_p4  <= PW'(r1_v0x) * PW'(r1_v2y);
            r2_p5  <= PW'(r1_v0y) * PW'(r1_v2x);
            r2_dcx <= r1_dcx;
            r2_dcy <= r1_dcy;
            r2_dbx <= r1_dbx;
            r2_dby <= r1_dby;
            r2_tax <= r1_tax;
            r2_tay <= r1_tay;
        end
    end

    // Stage 3: determinant and numerators, sign folded into the numerators.
    logic signed [XW-1:0] n_den, n_nu, n_nv;

    always_comb begin
        n_den = XW'(r2_p0) - XW'(r2_p1);
        n_nu  = XW'(r2_p2) - XW'(r2_p3);
        n_nv  = XW'(r2_p4) - XW'(r2_p5);
    end

    logic r3_vld, r3_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_degen <= (n_den == '0);
            o_den    <= n_den[XW-1] ? -n_den : n_den;
            o_nu     <= n_den[XW-1] ? -n_nu  : n_nu;
            o_nv     <= n_den[XW-1] ? -n_nv  : n_nv;
            o_dcx    <= r2_dcx;
            o_dcy    <= r2_dcy;
            o_dbx    <= r2_dbx;
            o_dby    <= r2_dby;
            o_tax    <= r2_tax;
            o_tay    <= r2_tay;
        end
    end

    always_comb begin
        o_ctl        = '0;
        o_ctl.valid  = r3_vld;
        o_ctl.degen  = r3_degen;
        o_ctl.in_tri = 1'b0;
    end

endmodule

### sv/ptb_interp.sv
// ----------------------------------------------------------------------------
// ptb_interp
// Inside test against the tolerance and the texture numerators.
// Two register stages: products, then compares and sums.
// ----------------------------------------------------------------------------
module ptb_interp #(
    parameter int CW = ptb_pkg::CoordWidthDef,
    parameter int FB = ptb_pkg::FracBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [ptb_pkg::TOL_W-1:0]     i_tol,
    input  ptb_pkg::t_ctl                 i_ctl,
    input  logic signed [2*CW+2:0]        i_den,
    input  logic signed [2*CW+2:0]        i_nu,
    input  logic signed [2*CW+2:0]        i_nv,
    input  logic signed [CW:0]            i_dcx,
    input  logic signed [CW:0]            i_dcy,
    input  logic signed [CW:0]            i_dbx,
    input  logic signed [CW:0]            i_dby,
    input  logic signed [CW-1:0]          i_tax,
    input  logic signed [CW-1:0]          i_tay,
    output ptb_pkg::t_ctl                 o_ctl,
    output logic signed [3*CW+4:0]        o_nx,
    output logic signed [3*CW+4:0]        o_ny,
    output logic signed [2*CW+2:0]        o_den,
    output logic signed [CW-1:0]          o_tax,
    output logic signed [CW-1:0]          o_tay
);
    import ptb_pkg::*;

    localparam int DIFW = CW + 1;
    localparam int XW   = 2 * DIFW + 1;
    localparam int TPW  = XW + DIFW;
    localparam int NXW  = TPW + 1;
    localparam int OTW  = ((FB > TOL_W) ? FB : TOL_W) + 2;
    localparam int CPW  = XW + OTW + FB + 2;

    logic signed [OTW-1:0] one_tol;
    assign one_tol = (OTW'(1) <<< FB) + OTW'($signed({1'b0, i_tol}));

    // Stage 4: products.
    t_ctl                  r4_ctl;
    logic signed [CPW-1:0] r4_tden, r4_otden;
    logic signed [TPW-1:0] r4_px1, r4_px2, r4_py1, r4_py2;
    logic signed [XW-1:0]  r4_nu, r4_nv, r4_den;
    logic signed [CW-1:0]  r4_tax, r4_tay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else if (i_en) begin
            r4_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_tden  <= CPW'($signed({1'b0, i_tol})) * CPW'(i_den);
            r4_otden <= CPW'(one_tol) * CPW'(i_den);
            r4_px1   <= TPW'(i_nu) * TPW'(i_dcx);
            r4_px2   <= TPW'(i_nv) * TPW'(i_dbx);
            r4_py1   <= TPW'(i_nu) * TPW'(i_dcy);
            r4_py2   <= TPW'(i_nv) * TPW'(i_dby);
            r4_nu    <= i_nu;
            r4_nv    <= i_nv;
            r4_den   <= i_den;
            r4_tax   <= i_tax;
            r4_tay   <= i_tay;
        end
    end

    // Stage 5: compares on exact rationals, texture numerator sums.
    logic signed [CPW-1:0] su, sv, ssum;
    logic                  n_inside;

    always_comb begin
        su       = CPW'(r4_nu) <<< FB;
        sv       = CPW'(r4_nv) <<< FB;
        ssum     = (CPW'(r4_nu) + CPW'(r4_nv)) <<< FB;
        n_inside = (su >= -r4_tden) && (sv >= -r4_tden) && (ssum <= r4_otden);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= '{valid: r4_ctl.valid, degen: r4_ctl.degen, in_tri: n_inside};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_nx  <= NXW'(r4_px1) + NXW'(r4_px2);
            o_ny  <= NXW'(r4_py1) + NXW'(r4_py2);
            o_den <= r4_den;
            o_tax <= r4_tax;
            o_tay <= r4_tay;
        end
    end

endmodule

### sv/ptb_div.sv
// ----------------------------------------------------------------------------
// ptb_div
// Pipelined restoring divider for one texture axis: rounds nx/den to the
// nearest step (ties upward), adds the base coordinate and saturates.
// Two preparation stages, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptb_div #(
    parameter int CW = ptb_pkg::CoordWidthDef
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [3*CW+4:0] i_nx,
    input  logic signed [2*CW+2:0] i_den,
    input  logic signed [CW-1:0]   i_base,
    output logic signed [CW-1:0]   o_res
);
    import ptb_pkg::*;

    localparam int XW  = 2 * CW + 3;
    localparam int NXW = 3 * CW + 5;
    localparam int MW  = NXW + 2;
    localparam int DW  = XW;
    localparam int QB  = CW + 1;
    localparam int CMW = MW + DW + QB;

    // Stage A: floor((2nx + den) / 2den) as a magnitude division.
    logic signed [MW-1:0] n_n;
    logic [MW-1:0]        n_m;
    logic [DW-1:0]        n_d;

    always_comb begin
        n_d = DW'(i_den) << 1;
        n_n = (MW'(i_nx) <<< 1) + MW'(i_den);
        // For a negative numerator the floor needs |N| + D - 1, which is ~N + D.
        n_m = n_n[MW-1] ? (MW'(~n_n) + MW'(n_d)) : MW'(n_n);
    end

    logic [MW-1:0]        ra_m;
    logic [DW-1:0]        ra_d;
    logic                 ra_neg;
    logic signed [CW-1:0] ra_base;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_m    <= n_m;
            ra_d    <= n_d;
            ra_neg  <= n_n[MW-1];
            ra_base <= i_base;
        end
    end

    // Stage B: an overflowing quotient saturates whatever the base is.
    logic [CMW-1:0] cmp_m, cmp_d;
    assign cmp_m = CMW'(ra_m);
    assign cmp_d = CMW'(ra_d) << QB;

    logic [DW-1:0]        r_rem  [0:QB];
    logic [QB-1:0]        r_q    [0:QB];
    logic [QB-1:0]        r_ml   [0:QB];
    logic [DW-1:0]        r_d    [0:QB];
    logic                 r_neg  [0:QB];
    logic                 r_ovf  [0:QB];
    logic signed [CW-1:0] r_base [0:QB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DW'(ra_m >> QB);
            r_q[0]    <= '0;
            r_ml[0]   <= ra_m[QB-1:0];
            r_d[0]    <= ra_d;
            r_neg[0]  <= ra_neg;
            r_ovf[0]  <= (cmp_m >= cmp_d);
            r_base[0] <= ra_base;
        end
    end

    for (genvar g = 1; g <= QB; g++) begin : g_step
        logic [DW:0] t;
        logic        ge;

        assign t  = {r_rem[g-1], r_ml[g-1][QB-1]};
        assign ge = (t >= {1'b0, r_d[g-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? DW'(t - {1'b0, r_d[g-1]}) : DW'(t);
                r_q[g]    <= {r_q[g-1][QB-2:0], ge};
                r_ml[g]   <= r_ml[g-1] << 1;
                r_d[g]    <= r_d[g-1];
                r_neg[g]  <= r_neg[g-1];
                r_ovf[g]  <= r_ovf[g-1];
                r_base[g] <= r_base[g-1];
            end
        end
    end

    localparam logic signed [QB+1:0] SatHi = (QB+2)'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [QB+1:0] SatLo = -SatHi - (QB+2)'(1);

    logic signed [QB:0]   qs;
    logic signed [QB+1:0] sum;

    always_comb begin
        qs  = r_neg[QB] ? -$signed({1'b0, r_q[QB]}) : $signed({1'b0, r_q[QB]});
        sum = (QB+2)'(r_base[QB]) + (QB+2)'(qs);
        if (r_ovf[QB]) begin
            o_res = r_neg[QB] ? CW'(SatLo) : CW'(SatHi);
        end else if (sum > SatHi) begin
            o_res = CW'(SatHi);
        end else if (sum < SatLo) begin
            o_res = CW'(SatLo);
        end else begin
            o_res = CW'(sum);
        end
    end

endmodule

### sv/point_in_triangle_barycentric_core.sv
// ----------------------------------------------------------------------------
// point_in_triangle_barycentric_core
// Barycentric point-in-triangle test with interpolated texture coordinate.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+-------------------------------
//  input    | in        | i_in_valid / o_in_stall | three positions, three texture
//           |           |                         | coordinates, query point
//  result   | out       | o_out_valid / i_out_stall | inside, degenerate, tex x/y
//  config   | in        | i_cfg_wr_en             | tolerance
//
//  One transaction is accepted every cycle unless the pipeline is stalled; the
//  depth is set by the one-bit-per-stage divider that rounds the texture offset.
//  Reset (synchronous, active low) clears all valid bits and sets the
//  tolerance to 16. A stall on the result side while a result is valid freezes
//  the whole pipeline, and the input is stalled in the same cycle.
// ----------------------------------------------------------------------------
module point_in_triangle_barycentric_core #(
    parameter int COORD_WIDTH = ptb_pkg::CoordWidthDef,
    parameter int FRAC_BITS   = ptb_pkg::FracBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ptb_pkg::TOL_W-1:0]     i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [31:0]                   i_vertex_a_pos,
    input  logic [31:0]                   i_vertex_b_pos,
    input  logic [31:0]                   i_vertex_c_pos,
    input  logic [31:0]                   i_vertex_a_tex,
    input  logic [31:0]                   i_vertex_b_tex,
    input  logic [31:0]                   i_vertex_c_tex,
    input  logic [31:0]                   i_query_point,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_inside_res,
    output logic                          o_degenerate,
    output logic signed [COORD_WIDTH-1:0] o_tex_x,
    output logic signed [COORD_WIDTH-1:0] o_tex_y
);
    import ptb_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int XW  = 2 * CW + 3;
    localparam int NXW = 3 * CW + 5;
    localparam int QB  = CW + 1;

    logic en;
    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    logic [TOL_W-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    t_ctl                 g_ctl;
    logic signed [XW-1:0] g_den, g_nu, g_nv;
    logic signed [CW:0]   g_dcx, g_dcy, g_dbx, g_dby;
    logic signed [CW-1:0] g_tax, g_tay;

    ptb_geom #(.CW(CW)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_a_pos (i_vertex_a_pos),
        .i_b_pos (i_vertex_b_pos),
        .i_c_pos (i_vertex_c_pos),
        .i_a_tex (i_vertex_a_tex),
        .i_b_tex (i_vertex_b_tex),
        .i_c_tex (i_vertex_c_tex),
        .i_pt    (i_query_point),
        .o_ctl   (g_ctl),
        .o_den   (g_den),
        .o_nu    (g_nu),
        .o_nv    (g_nv),
        .o_dcx   (g_dcx),
        .o_dcy   (g_dcy),
        .o_dbx   (g_dbx),
        .o_dby   (g_dby),
        .o_tax   (g_tax),
        .o_tay   (g_tay)
    );

    t_ctl                  t_ctl_s;
    logic signed [NXW-1:0] t_nx, t_ny;
    logic signed [XW-1:0]  t_den;
    logic signed [CW-1:0]  t_tax, t_tay;

    ptb_interp #(.CW(CW), .FB(FRAC_BITS)) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tol   (r_tol),
        .i_ctl   (g_ctl),
        .i_den   (g_den),
        .i_nu    (g_nu),
        .i_nv    (g_nv),
        .i_dcx   (g_dcx),
        .i_dcy   (g_dcy),
        .i_dbx   (g_dbx),
        .i_dby   (g_dby),
        .i_tax   (g_tax),
        .i_tay   (g_tay),
        .o_ctl   (t_ctl_s),
        .o_nx    (t_nx),
        .o_ny    (t_ny),
        .o_den   (t_den),
        .o_tax   (t_tax),
        .o_tay   (t_tay)
    );

    logic signed [CW-1:0] res_x, res_y;

    ptb_div #(.CW(CW)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_nx   (t_nx),
        .i_den  (t_den),
        .i_base (t_tax),
        .o_res  (res_x)
    );

    ptb_div #(.CW(CW)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_nx   (t_ny),
        .i_den  (t_den),
        .i_base (t_tay),
        .o_res  (res_y)
    );

    // Control bits matching the divider's depth.
    t_ctl r_ctl [0:QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB + 1; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (en) begin
            r_ctl[0] <= t_ctl_s;
            for (int k = 1; k <= QB + 1; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    logic hit;
    assign hit = r_ctl[QB+1].in_tri && !r_ctl[QB+1].degen;

    logic                 r_ovalid, r_inside, r_degen;
    logic signed [CW-1:0] r_tex_x, r_tex_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= r_ctl[QB+1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_inside <= hit;
            r_degen  <= r_ctl[QB+1].degen;
            r_tex_x  <= hit ? res_x : '0;
            r_tex_y  <= hit ? res_y : '0;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_inside_res = r_inside;
    assign o_degenerate = r_degen;
    assign o_tex_x      = r_tex_x;
    assign o_tex_y      = r_tex_y;

endmodule

### sv/ptb_checker.sv
// ----------------------------------------------------------------------------
// ptb_checker
// Port-level checks on the point-in-triangle core, bound to the top level.
// ----------------------------------------------------------------------------
module ptb_checker #(
    parameter int COORD_WIDTH = ptb_pkg::CoordWidthDef
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic                   o_inside_res,
    input logic                   o_degenerate,
    input logic [COORD_WIDTH-1:0] o_tex_x,
    input logic [COORD_WIDTH-1:0] o_tex_y
);

    // No result may appear in the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A held result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tex_x) && $stable(o_tex_y)
            && $stable(o_inside_res) && $stable(o_degenerate))
        else $error("stalled result changed");

    // A frozen output freezes the pipeline, so the input must stall too.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input accepted while output is blocked");

    // An outside or degenerate point reports a zero texture coordinate.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_inside_res |-> (o_tex_x == '0) && (o_tex_y == '0))
        else $error("texture coordinate non-zero for an outside point");

    // A degenerate triangle is never inside.
    a_degen_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |-> !o_inside_res)
        else $error("degenerate triangle reported inside");

endmodule

bind point_in_triangle_barycentric_core ptb_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ptb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_inside_res (o_inside_res),
    .o_degenerate (o_degenerate),
    .o_tex_x      (o_tex_x),
    .o_tex_y      (o_tex_y)
);
